// ----- hdl/hcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbp_pkg: shared definitions for the Huffman code bit packer
// Field widths, action codes and the item passed from the table stage to the
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

   localparam int ACTION_W  = 2;
   localparam int SYMBOL_W  = 8;
   localparam int CODE_W    = 32;
   localparam int LEN_W     = 6;
   localparam int BYTE_BITS = 8;

   localparam int DEF_SYMBOL_COUNT  = 256;
   localparam int DEF_MAX_CODE_BITS = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_ENCODE = 2'd1,
      ACT_FLUSH  = 2'd2
   } action_type;

   // Work handed to the accumulator: an encode with its table entry, or a flush.
   typedef struct packed {
      logic              valid;
      logic              flush;
      logic [CODE_W-1:0] word;
      logic [LEN_W-1:0]  len;
   } hcbp_item_type;

endpackage

`default_nettype wire

// ----- hdl/hcbp_if.sv -----
// ----------------------------------------------------------------------------
// hcbp_if: request and response channels of the Huffman code bit packer
// Valid/ready channels; a request moves at a clock edge with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbp_req_if;
   logic                          valid;
   logic                          ready;
   logic [hcbp_pkg::ACTION_W-1:0] action;
   logic [hcbp_pkg::SYMBOL_W-1:0] symbol;
   logic [hcbp_pkg::CODE_W-1:0]   code_word;
   logic [hcbp_pkg::LEN_W-1:0]    code_len;

   modport source (output valid, action, symbol, code_word, code_len, input ready);
   modport sink   (input valid, action, symbol, code_word, code_len, output ready);
endinterface

interface hcbp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hcbp_pkg::BYTE_BITS-1:0] packed_byte;
   logic                           last;

   modport source (output valid, packed_byte, last, input ready);
   modport sink   (input valid, packed_byte, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/hcbp_packer.sv -----
// ----------------------------------------------------------------------------
// hcbp_packer: bit accumulator and output register
// Merges code words into the accumulator; a byte per cycle while rsp is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_packer #(
   parameter int MAX_CODE_BITS = hcbp_pkg::DEF_MAX_CODE_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire hcbp_pkg::hcbp_item_type item,
   output logic                         take,
   hcbp_rsp_if.source                   rsp
);

   localparam int ACC_W = MAX_CODE_BITS + hcbp_pkg::BYTE_BITS - 1;
   localparam int CNT_W = $clog2(ACC_W + 1);
   localparam logic [CNT_W-1:0] BYTE_CNT = CNT_W'(hcbp_pkg::BYTE_BITS);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [hcbp_pkg::BYTE_BITS-1:0] rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             slot_free, can_emit, emit, take_enc, take_fl;
   logic [CNT_W-1:0] cnt_after, shamt, len_ext;
   logic [ACC_W-1:0] shifted;
   logic [hcbp_pkg::BYTE_BITS-1:0] fl_byte;

   always_comb begin
      slot_free = !rsp_valid_ff || rsp.ready;
      can_emit  = cnt_ff >= BYTE_CNT;
      emit      = can_emit && slot_free;
      cnt_after = emit ? cnt_ff - BYTE_CNT : cnt_ff;
      shamt     = cnt_ff - BYTE_CNT;
      shifted   = acc_ff >> shamt;
      fl_byte   = acc_ff[hcbp_pkg::BYTE_BITS-1:0] << (BYTE_CNT - cnt_ff);
      len_ext   = CNT_W'(item.len);
      // merge as soon as the bytes in flight leave fewer than eight bits
      take_enc  = item.valid && !item.flush && (cnt_after < BYTE_CNT);
      take_fl   = item.valid && item.flush && !can_emit &&
                  ((cnt_ff == '0) || slot_free);
      take      = take_enc || take_fl;
   end

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_after;
      if (take_enc) begin
         acc_in = (acc_ff << len_ext) | ACC_W'(item.word);
         cnt_in = cnt_after + len_ext;
      end else if (take_fl) begin
         cnt_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = shifted[hcbp_pkg::BYTE_BITS-1:0];
         rsp_last_in  = shamt < BYTE_CNT;
      end else if (take_fl && (cnt_ff != '0)) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = fl_byte;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.packed_byte = rsp_byte_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hdl/huffman_code_bit_packer.sv -----
// ----------------------------------------------------------------------------
// huffman_code_bit_packer: Huffman encoder back end
// Code table in a synchronous memory, bit accumulator and byte output.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake       payload
//  req_chan   in   valid / ready   action, symbol, code_word, code_len
//  rsp_chan   out  valid / ready   packed_byte, last
//
// A request is taken each cycle while the table stage is free. A load writes
// the table in the cycle it is taken; an encode reads it and reaches the
// accumulator in the next cycle. The single output register sends one byte
// per cycle while the response channel is ready. Reset clears the accumulator
// bit count and both valid flags; the table is not cleared and needs no sweep.
// A stalled response blocks merges only once a full byte waits, and the table
// stage holds its request until it is merged.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer #(
   parameter int SYMBOL_COUNT  = hcbp_pkg::DEF_SYMBOL_COUNT,
   parameter int MAX_CODE_BITS = hcbp_pkg::DEF_MAX_CODE_BITS
) (
   input wire logic   clock,
   input wire logic   reset,
   hcbp_req_if.sink   req_chan,
   hcbp_rsp_if.source rsp_chan
);

   localparam int IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int MLEN_W = $clog2(MAX_CODE_BITS + 1);
   localparam int ENT_W  = MAX_CODE_BITS + MLEN_W;
   localparam int CMP_W  = hcbp_pkg::SYMBOL_W + 1;

   // code table: {code word, length}
   logic [ENT_W-1:0] code_mem [SYMBOL_COUNT];

   logic [MAX_CODE_BITS-1:0] rd_word_ff;
   logic [MLEN_W-1:0]        rd_len_ff;
   logic                     a_valid_ff, a_valid_in;
   logic                     a_flush_ff, a_flush_in;

   logic                          req_take, in_range, is_load, is_enc, is_flush, take;
   logic [IDX_W-1:0]              idx;
   logic [hcbp_pkg::LEN_W-1:0]    len_sat;
   logic [hcbp_pkg::CODE_W-1:0]   word_masked;
   hcbp_pkg::hcbp_item_type       item;

   always_comb begin
      in_range = CMP_W'(req_chan.symbol) < CMP_W'(SYMBOL_COUNT);
      idx      = req_chan.symbol[IDX_W-1:0];
      is_load  = 1'b0;
      is_enc   = 1'b0;
      is_flush = 1'b0;
      unique case (req_chan.action)
         hcbp_pkg::ACT_LOAD:   is_load  = 1'b1;
         hcbp_pkg::ACT_ENCODE: is_enc   = 1'b1;
         hcbp_pkg::ACT_FLUSH:  is_flush = 1'b1;
         default:              ;
      endcase
      // saturate the length and drop code bits above it
      len_sat = (req_chan.code_len > hcbp_pkg::LEN_W'(MAX_CODE_BITS)) ?
                hcbp_pkg::LEN_W'(MAX_CODE_BITS) : req_chan.code_len;
      word_masked = req_chan.code_word & ~({hcbp_pkg::CODE_W{1'b1}} << len_sat);
   end

   // hold the stage until the accumulator merges it
   assign req_chan.ready = !a_valid_ff || take;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (req_take && is_load && in_range) begin
         code_mem[idx] <= {word_masked[MAX_CODE_BITS-1:0], MLEN_W'(len_sat)};
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && is_enc && in_range) begin
         {rd_word_ff, rd_len_ff} <= code_mem[idx];
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff && !take;
      a_flush_in = a_flush_ff;
      if (req_take) begin
         a_valid_in = (is_enc && in_range) || is_flush;
         a_flush_in = is_flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_flush_ff <= a_flush_in;
   end

   always_comb begin
      item.valid = a_valid_ff;
      item.flush = a_flush_ff;
      item.word  = hcbp_pkg::CODE_W'(rd_word_ff);
      item.len   = hcbp_pkg::LEN_W'(rd_len_ff);
   end

   hcbp_packer #(
      .MAX_CODE_BITS(MAX_CODE_BITS)
   ) u_packer (
      .clock(clock),
      .reset(reset),
      .item (item),
      .take (take),
      .rsp  (rsp_chan)
   );

endmodule

`default_nettype wire
